>>> rtl/sweep_pkg.sv
package sweep_pkg;

  localparam int MAX_POINTS = 8;
  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  localparam int ANGLE_W = 8;
  localparam int SPEED_W = 7;
  localparam int DIST_W = 16;
  localparam int TIME_W = 32;
  localparam int REP_IDX_W = 3;

  localparam int IN_W = 64;
  localparam int OUT_W = 40;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_ANGLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ANGLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_SPEED = 2'd2;

  localparam logic [ANGLE_W-1:0] MIN_ANGLE_RST = 8'd0;
  localparam logic [ANGLE_W-1:0] MAX_ANGLE_RST = 8'd180;
  localparam logic [SPEED_W-1:0] SPEED_RST = 7'd50;
  localparam logic [SPEED_W-1:0] DWELL_BASE = 7'd99;

  // Division of the sweep range by 30 is done as a multiply by 2185 / 2^16,
  // which is exact for every 8-bit range.
  localparam int RECIP_W = 12;
  localparam int RECIP_SH = 16;
  localparam logic [RECIP_W-1:0] RECIP_30 = 12'd2185;
  localparam int Q30_W = ANGLE_W + RECIP_W - RECIP_SH;
  localparam int STOPS_RAW_W = Q30_W + 1;
  localparam int MIN_STOPS = 2;

  localparam int PROD_W = IDX_W + ANGLE_W;
  localparam int DIV_CNT_W = $clog2(PROD_W);

  localparam logic [1:0] PH_MOVE = 2'd0;
  localparam logic [1:0] PH_SERVO = 2'd1;
  localparam logic [1:0] PH_ECHO = 2'd2;
  localparam logic [1:0] PH_DWELL = 2'd3;

  typedef struct packed {
    logic [3:0]         pad;
    logic [ANGLE_W-1:0] manual_angle;
    logic               manual_write;
    logic [DIST_W-1:0]  echo_distance_mm;
    logic               echo_ready;
    logic               servo_busy;
    logic [TIME_W-1:0]  now_ms;
    logic               scan_enable;
  } in_item_t;

  typedef struct packed {
    logic [1:0]           pad;
    logic [REP_IDX_W-1:0] report_index;
    logic [DIST_W-1:0]    report_distance;
    logic [ANGLE_W-1:0]   report_angle;
    logic                 report_valid;
    logic                 trigger_echo;
    logic [ANGLE_W-1:0]   servo_angle;
    logic                 servo_write;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_last;
  } dp_sts_t;

endpackage

>>> rtl/servo_sweep_scan_sequencer.sv
// Channel   Direction  Width  Contents
// s_axis    in         64     one poll: run level, time, servo and echo status, manual write
// m_axis    out        40     one result per poll: servo command, trigger, report
// cfg       in         2+8    register index and write data
//
// Each poll runs through the bit-serial divider that places the stop angle, one quotient
// bit per cycle, before its result is written to the output register. A new poll is
// accepted only after the previous one has been committed to the output register.
// A result waiting in the output register does not block the next poll; the block
// stalls only when a second result is ready before the first is taken.
// Reset clears the registers to their defaults and the sweep to the first stop.
module servo_sweep_scan_sequencer
  import sweep_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // scan_enable, now_ms, servo_busy, echo_ready, echo_distance_mm, manual_write,
  // manual_angle.
  input  logic [IN_W-1:0]      s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // servo_write, servo_angle, trigger_echo, report_valid, report_angle,
  // report_distance, report_index.
  output logic [OUT_W-1:0]     m_axis_tdata,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ANGLE_W-1:0]   cfg_data_i
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  assign cfg_ready_o = 1'b1;

  sweep_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  sweep_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .out_data_o  (m_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

>>> rtl/sweep_ctrl.sv
module sweep_ctrl
  import sweep_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_valid_i,
  output logic      s_ready_o,
  output logic      m_valid_o,
  input  logic      m_ready_i,
  input  dp_sts_t   sts_i,
  output ctrl_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state_q, state_d;
  logic       m_valid_q, m_valid_d;
  logic       out_free;

  assign out_free = !m_valid_q || m_ready_i;
  assign s_ready_o = (state_q == S_IDLE);
  assign m_valid_o = m_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (m_valid_q && m_ready_i) begin
      m_valid_d = 1'b0;
    end
    if (cmd_o.commit) begin
      m_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

endmodule

>>> rtl/sweep_dp.sv
module sweep_dp
  import sweep_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ANGLE_W-1:0]   cfg_data_i,
  input  logic [IN_W-1:0]      in_data_i,
  output logic [OUT_W-1:0]     out_data_o,
  input  ctrl_cmd_t            cmd_i,
  output dp_sts_t              sts_o
);

  logic [ANGLE_W-1:0]     min_angle_q;
  logic [ANGLE_W-1:0]     max_angle_q;
  logic [SPEED_W-1:0]     scan_speed_q;

  logic [1:0]             phase_q, phase_d;
  logic [IDX_W-1:0]       point_q, point_d;
  logic                   up_q, up_d;
  logic [TIME_W-1:0]      deadline_q, deadline_d;

  in_item_t               item_q;
  logic [PROD_W-1:0]      div_q;
  logic [IDX_W-1:0]       rem_q;
  logic [DIV_CNT_W-1:0]   cnt_q;
  out_item_t              out_q, out_d;

  logic [ANGLE_W-1:0]     lo, hi, range;
  logic [ANGLE_W+RECIP_W-1:0] q30_prod;
  logic [STOPS_RAW_W-1:0] stops_raw;
  logic [CNT_W-1:0]       stops;
  logic [IDX_W-1:0]       last_idx;
  logic [IDX_W-1:0]       idx;
  logic [PROD_W-1:0]      prod;
  logic [IDX_W:0]         trial;
  logic                   q_bit;
  logic [ANGLE_W-1:0]     stop_angle;
  logic [SPEED_W-1:0]     dwell;
  logic [IDX_W-1:0]       next_idx;
  logic                   next_up;

  always_comb begin
    if (max_angle_q < min_angle_q) begin
      lo = max_angle_q;
      hi = min_angle_q;
    end else begin
      lo = min_angle_q;
      hi = max_angle_q;
    end
    range = hi - lo;
    q30_prod = {{RECIP_W{1'b0}}, range} * {{ANGLE_W{1'b0}}, RECIP_30};
    stops_raw = {1'b0, q30_prod[ANGLE_W+RECIP_W-1:RECIP_SH]} + STOPS_RAW_W'(MIN_STOPS);
    if (stops_raw > STOPS_RAW_W'(MAX_POINTS)) begin
      stops = CNT_W'(MAX_POINTS);
    end else begin
      stops = CNT_W'(stops_raw);
    end
    last_idx = IDX_W'(stops - CNT_W'(1));
    idx = (CNT_W'(point_q) < stops) ? point_q : last_idx;
    prod = {{ANGLE_W{1'b0}}, idx} * {{IDX_W{1'b0}}, range};
  end

  assign trial = {rem_q, div_q[PROD_W-1]};
  assign q_bit = (trial >= {1'b0, last_idx});
  assign sts_o.div_last = (cnt_q == '0);
  assign stop_angle = lo + div_q[ANGLE_W-1:0];
  assign dwell = (scan_speed_q >= DWELL_BASE) ? '0 : DWELL_BASE - scan_speed_q;

  always_comb begin
    next_up = up_q;
    if (up_q) begin
      if (idx == last_idx) begin
        next_idx = last_idx - IDX_W'(1);
        next_up = 1'b0;
      end else begin
        next_idx = idx + IDX_W'(1);
      end
    end else begin
      if (idx == '0) begin
        next_idx = IDX_W'(1);
        next_up = 1'b1;
      end else begin
        next_idx = idx - IDX_W'(1);
      end
    end
    if (next_idx == '0) begin
      next_up = 1'b1;
    end
  end

  always_comb begin
    phase_d = phase_q;
    point_d = point_q;
    up_d = up_q;
    deadline_d = deadline_q;
    out_d = '0;
    if (!item_q.scan_enable) begin
      if (item_q.manual_write) begin
        out_d.servo_write = 1'b1;
        out_d.servo_angle = item_q.manual_angle;
      end
    end else begin
      case (phase_q)
        PH_MOVE: begin
          out_d.servo_write = 1'b1;
          out_d.servo_angle = stop_angle;
          phase_d = PH_SERVO;
        end
        PH_SERVO: begin
          if (!item_q.servo_busy) begin
            out_d.trigger_echo = 1'b1;
            phase_d = PH_ECHO;
          end
        end
        PH_ECHO: begin
          if (item_q.echo_ready) begin
            out_d.report_valid = 1'b1;
            out_d.report_angle = stop_angle;
            out_d.report_distance = item_q.echo_distance_mm;
            out_d.report_index = REP_IDX_W'(idx);
            point_d = next_idx;
            up_d = next_up;
            if (dwell != '0) begin
              deadline_d = item_q.now_ms + TIME_W'(dwell);
              phase_d = PH_DWELL;
            end else begin
              phase_d = PH_MOVE;
            end
          end
        end
        default: begin
          if (item_q.now_ms > deadline_q) begin
            phase_d = PH_MOVE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_angle_q <= MIN_ANGLE_RST;
      max_angle_q <= MAX_ANGLE_RST;
      scan_speed_q <= SPEED_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MIN_ANGLE: min_angle_q <= cfg_data_i;
        CFG_MAX_ANGLE: max_angle_q <= cfg_data_i;
        CFG_SCAN_SPEED: scan_speed_q <= cfg_data_i[SPEED_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_MOVE;
      point_q <= '0;
      up_q <= 1'b1;
      deadline_q <= '0;
    end else if (cmd_i.commit) begin
      phase_q <= phase_d;
      point_q <= point_d;
      up_q <= up_d;
      deadline_q <= deadline_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.load) begin
      cnt_q <= DIV_CNT_W'(PROD_W - 1);
    end else if (cmd_i.step && cnt_q != '0) begin
      cnt_q <= cnt_q - DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_item_t'(in_data_i);
      div_q <= prod;
      rem_q <= '0;
    end else if (cmd_i.step) begin
      div_q <= {div_q[PROD_W-2:0], q_bit};
      rem_q <= q_bit ? IDX_W'(trial - {1'b0, last_idx}) : IDX_W'(trial);
    end
    if (cmd_i.commit) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = OUT_W'(out_q);

endmodule
